// ----- src/cpp_pkg.sv -----
package cpp_pkg;

    localparam int CPP_WORD_BITS = 32;
    localparam int CPP_FRAC_BITS = 24;
    localparam int CPP_CFG_IDX_BITS = 3;

    typedef enum logic [CPP_CFG_IDX_BITS-1:0] {
        CFG_ROT_GAIN,
        CFG_FIELD_GAIN,
        CFG_X_MIN,
        CFG_X_MAX,
        CFG_Y_MIN,
        CFG_Y_MAX,
        CFG_Z_MIN,
        CFG_Z_MAX
    } t_cfg_idx;

endpackage

// ----- src/cpp_in_if.sv -----
interface cpp_in_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] rot_x;
    logic signed [WORD_BITS-1:0] rot_y;
    logic signed [WORD_BITS-1:0] rot_z;
    logic signed [WORD_BITS-1:0] accel_x;
    logic signed [WORD_BITS-1:0] accel_y;
    logic signed [WORD_BITS-1:0] accel_z;
    logic signed [WORD_BITS-1:0] prev_x;
    logic signed [WORD_BITS-1:0] prev_y;
    logic signed [WORD_BITS-1:0] prev_z;
    logic signed [WORD_BITS-1:0] cur_x;
    logic signed [WORD_BITS-1:0] cur_y;
    logic signed [WORD_BITS-1:0] cur_z;

    modport source (
        output valid, rot_x, rot_y, rot_z, accel_x, accel_y, accel_z,
               prev_x, prev_y, prev_z, cur_x, cur_y, cur_z,
        input  ready
    );
    modport sink (
        input  valid, rot_x, rot_y, rot_z, accel_x, accel_y, accel_z,
               prev_x, prev_y, prev_z, cur_x, cur_y, cur_z,
        output ready
    );
endinterface

// ----- src/cpp_out_if.sv -----
interface cpp_out_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] next_x;
    logic signed [WORD_BITS-1:0] next_y;
    logic signed [WORD_BITS-1:0] next_z;
    logic signed [WORD_BITS-1:0] last_x;
    logic signed [WORD_BITS-1:0] last_y;
    logic signed [WORD_BITS-1:0] last_z;

    modport source (
        output valid, next_x, next_y, next_z, last_x, last_y, last_z,
        input  ready
    );
    modport sink (
        input  valid, next_x, next_y, next_z, last_x, last_y, last_z,
        output ready
    );
endinterface

// ----- src/charged_particle_position_push.sv -----
// words are signed fixed point, Q8.24 at the default parameters
// throughput: one particle per cycle, set by the one-bit-per-stage reciprocal pipe
// a stalled result holds the whole pipe; no item is lost or repeated
// reset (synchronous, active low) empties the pipe and loads the gains with 1.0
// and the clamp box with the full word range
module charged_particle_position_push
    import cpp_pkg::*;
#(
    parameter int WORD_BITS = CPP_WORD_BITS,
    parameter int FRAC_BITS = CPP_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CPP_CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [WORD_BITS-1:0]        i_cfg_data,
    cpp_in_if.sink                      i_item,
    cpp_out_if.source                   o_res
);
    localparam int DL = 2 * FRAC_BITS + 2;
    localparam int NS = DL + 5;
    localparam int W  = WORD_BITS;

    typedef logic signed [W-1:0] t_word;

    localparam t_word VMAX = {1'b0, {(W-1){1'b1}}};
    localparam t_word VMIN = {1'b1, {(W-1){1'b0}}};
    localparam t_word ONE  = t_word'(W'(1) << FRAC_BITS);
    localparam logic [2*W:0] HALF = (2*W+1)'(1) << (FRAC_BITS - 1);

    function automatic t_word f_sat(input logic [W:0] v);
        if (v[W] != v[W-1]) begin
            return v[W] ? VMIN : VMAX;
        end
        return t_word'(v[W-1:0]);
    endfunction

    function automatic t_word f_add(input t_word a, input t_word b);
        return f_sat({a[W-1], a} + {b[W-1], b});
    endfunction

    function automatic t_word f_sub(input t_word a, input t_word b);
        return f_sat({a[W-1], a} - {b[W-1], b});
    endfunction

    function automatic t_word f_mul(input t_word x, input t_word y);
        logic           neg;
        logic [W-1:0]   ma;
        logic [W-1:0]   mb;
        logic [2*W-1:0] p;
        logic [2*W:0]   rnd;
        logic [2*W:0]   res;
        logic [2*W:0]   lim;
        logic [W-1:0]   lo;
        neg = x[W-1] ^ y[W-1];
        ma  = x[W-1] ? W'(-x) : W'(x);
        mb  = y[W-1] ? W'(-y) : W'(y);
        p   = {{W{1'b0}}, ma} * {{W{1'b0}}, mb};
        rnd = {1'b0, p} + HALF;
        res = rnd >> FRAC_BITS;
        lim = (2*W+1)'({1'b0, VMAX}) + (2*W+1)'(neg);
        if (res > lim) begin
            res = lim;
        end
        lo = res[W-1:0];
        return neg ? t_word'(~lo + 1'b1) : t_word'(lo);
    endfunction

    // config registers
    t_word r_gain_rot;
    t_word r_gain_fld;
    t_word r_lo [3];
    t_word r_hi [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_rot <= ONE;
            r_gain_fld <= ONE;
            for (int k = 0; k < 3; k++) begin
                r_lo[k] <= VMIN;
                r_hi[k] <= VMAX;
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ROT_GAIN:   r_gain_rot <= t_word'(i_cfg_data);
                CFG_FIELD_GAIN: r_gain_fld <= t_word'(i_cfg_data);
                CFG_X_MIN:      r_lo[0]    <= t_word'(i_cfg_data);
                CFG_X_MAX:      r_hi[0]    <= t_word'(i_cfg_data);
                CFG_Y_MIN:      r_lo[1]    <= t_word'(i_cfg_data);
                CFG_Y_MAX:      r_hi[1]    <= t_word'(i_cfg_data);
                CFG_Z_MIN:      r_lo[2]    <= t_word'(i_cfg_data);
                CFG_Z_MAX:      r_hi[2]    <= t_word'(i_cfg_data);
            endcase
        end
    end

    // pipe control
    logic          en;
    logic [NS-1:0] r_vld;

    assign en           = !r_vld[NS-1] || o_res.ready;
    assign i_item.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], i_item.valid};
        end
    end

    // stage 1: gains
    t_word r1_p [3];
    t_word r1_e [3];
    t_word r1_a [3];
    t_word r1_c [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p[0] <= f_mul(r_gain_rot, i_item.rot_x);
            r1_p[1] <= f_mul(r_gain_rot, i_item.rot_y);
            r1_p[2] <= f_mul(r_gain_rot, i_item.rot_z);
            r1_e[0] <= f_mul(r_gain_fld, i_item.accel_x);
            r1_e[1] <= f_mul(r_gain_fld, i_item.accel_y);
            r1_e[2] <= f_mul(r_gain_fld, i_item.accel_z);
            r1_a[0] <= i_item.prev_x;
            r1_a[1] <= i_item.prev_y;
            r1_a[2] <= i_item.prev_z;
            r1_c[0] <= i_item.cur_x;
            r1_c[1] <= i_item.cur_y;
            r1_c[2] <= i_item.cur_z;
        end
    end

    // stage 2: squares and cross products
    t_word r2_pxx, r2_pxy, r2_pxz, r2_pyy, r2_pyz, r2_pzz;
    t_word r2_zay, r2_yaz, r2_xaz, r2_zax, r2_yax, r2_xay;
    t_word r2_p [3];
    t_word r2_e [3];
    t_word r2_a [3];
    t_word r2_c [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_pxx <= f_mul(r1_p[0], r1_p[0]);
            r2_pxy <= f_mul(r1_p[0], r1_p[1]);
            r2_pxz <= f_mul(r1_p[0], r1_p[2]);
            r2_pyy <= f_mul(r1_p[1], r1_p[1]);
            r2_pyz <= f_mul(r1_p[1], r1_p[2]);
            r2_pzz <= f_mul(r1_p[2], r1_p[2]);
            r2_zay <= f_mul(r1_p[2], r1_a[1]);
            r2_yaz <= f_mul(r1_p[1], r1_a[2]);
            r2_xaz <= f_mul(r1_p[0], r1_a[2]);
            r2_zax <= f_mul(r1_p[2], r1_a[0]);
            r2_yax <= f_mul(r1_p[1], r1_a[0]);
            r2_xay <= f_mul(r1_p[0], r1_a[1]);
            r2_p   <= r1_p;
            r2_e   <= r1_e;
            r2_a   <= r1_a;
            r2_c   <= r1_c;
        end
    end

    // stage 3: denominator, displacement, rotation matrix
    t_word r3_den;
    t_word r3_d [3];
    t_word r3_m [9];
    t_word r3_e [3];
    t_word r3_c [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_den  <= f_add(f_add(f_add(ONE, r2_pxx), r2_pyy), r2_pzz);
            r3_d[0] <= f_add(f_sub(f_sub(f_add(r2_c[0], r2_c[0]), r2_a[0]), r2_zay), r2_yaz);
            r3_d[1] <= f_add(f_sub(f_sub(f_add(r2_c[1], r2_c[1]), r2_a[1]), r2_xaz), r2_zax);
            r3_d[2] <= f_add(f_sub(f_sub(f_add(r2_c[2], r2_c[2]), r2_a[2]), r2_yax), r2_xay);
            r3_m[0] <= f_add(ONE, r2_pxx);
            r3_m[1] <= f_add(r2_p[2], r2_pxy);
            r3_m[2] <= f_sub(r2_pxz, r2_p[1]);
            r3_m[3] <= f_sub(r2_pxy, r2_p[2]);
            r3_m[4] <= f_add(ONE, r2_pyy);
            r3_m[5] <= f_add(r2_pyz, r2_p[0]);
            r3_m[6] <= f_add(r2_pxz, r2_p[1]);
            r3_m[7] <= f_sub(r2_pyz, r2_p[0]);
            r3_m[8] <= f_add(ONE, r2_pzz);
            r3_e    <= r2_e;
            r3_c    <= r2_c;
        end
    end

    logic [W-1:0] recip;

    cpp_recip #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_recip (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_den   (r3_den),
        .o_recip (recip)
    );

    // stage 4: matrix times displacement
    t_word r4_md [9];
    t_word r4_e [3];
    t_word r4_c [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r4_md[3*k]   <= f_mul(r3_m[3*k],   r3_d[0]);
                r4_md[3*k+1] <= f_mul(r3_m[3*k+1], r3_d[1]);
                r4_md[3*k+2] <= f_mul(r3_m[3*k+2], r3_d[2]);
            end
            r4_e <= r3_e;
            r4_c <= r3_c;
        end
    end

    // row sums, then wait for the reciprocal
    t_word r_dl_s [DL-1][3];
    t_word r_dl_e [DL-1][3];
    t_word r_dl_c [DL-1][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_dl_s[0][k] <= f_add(f_add(r4_md[3*k], r4_md[3*k+1]), r4_md[3*k+2]);
                r_dl_e[0][k] <= r4_e[k];
                r_dl_c[0][k] <= r4_c[k];
            end
            for (int j = 1; j < DL - 1; j++) begin
                r_dl_s[j] <= r_dl_s[j-1];
                r_dl_e[j] <= r_dl_e[j-1];
                r_dl_c[j] <= r_dl_c[j-1];
            end
        end
    end

    // scale by reciprocal
    t_word r5_t [3];
    t_word r5_e [3];
    t_word r5_c [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r5_t[k] <= f_mul(t_word'(recip), r_dl_s[DL-2][k]);
            end
            r5_e <= r_dl_e[DL-2];
            r5_c <= r_dl_c[DL-2];
        end
    end

    // add field term and clamp
    t_word r6_n [3];
    t_word r6_c [3];
    t_word n_pos [3];
    t_word n_last [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_pos[k]  = f_add(r5_t[k], r5_e[k]);
            n_last[k] = r5_c[k];
            if (n_pos[k] < r_lo[k]) begin
                n_pos[k]  = r_lo[k];
                n_last[k] = r_lo[k];
            end
            if (n_pos[k] > r_hi[k]) begin
                n_pos[k]  = r_hi[k];
                n_last[k] = r_hi[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_n <= n_pos;
            r6_c <= n_last;
        end
    end

    assign o_res.valid  = r_vld[NS-1];
    assign o_res.next_x = r6_n[0];
    assign o_res.next_y = r6_n[1];
    assign o_res.next_z = r6_n[2];
    assign o_res.last_x = r6_c[0];
    assign o_res.last_y = r6_c[1];
    assign o_res.last_z = r6_c[2];

    a_recip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[DL+2] |-> (recip <= W'(ONE) && recip != '0))
        else $error("reciprocal out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

endmodule

// ----- src/cpp_recip.sv -----
module cpp_recip
    import cpp_pkg::*;
#(
    parameter int WORD_BITS = CPP_WORD_BITS,
    parameter int FRAC_BITS = CPP_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [WORD_BITS-1:0] i_den,
    output logic [WORD_BITS-1:0] o_recip
);
    localparam int Q = 2 * FRAC_BITS + 1;

    logic [WORD_BITS-1:0] r_rem [Q];
    logic [WORD_BITS-1:0] r_d   [Q];
    logic [Q-1:0]         r_q   [Q];
    logic [WORD_BITS-1:0] r_recip;

    // one quotient bit per stage, restoring
    for (genvar j = 0; j < Q; j++) begin : g_step
        logic [WORD_BITS-1:0] rem_in;
        logic [WORD_BITS-1:0] d_in;
        logic [Q-1:0]         q_in;
        logic [WORD_BITS:0]   remsh;
        logic [WORD_BITS:0]   diff;
        logic                 ge;

        if (j == 0) begin : g_first
            assign rem_in = '0;
            assign d_in   = i_den;
            assign q_in   = '0;
            assign remsh  = {rem_in, 1'b1};
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign d_in   = r_d[j-1];
            assign q_in   = r_q[j-1];
            assign remsh  = {rem_in, 1'b0};
        end

        assign ge   = remsh >= {1'b0, d_in};
        assign diff = remsh - {1'b0, d_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? diff[WORD_BITS-1:0] : remsh[WORD_BITS-1:0];
                r_d[j]   <= d_in;
                r_q[j]   <= {q_in[Q-2:0], ge};
            end
        end
    end

    logic [WORD_BITS-1:0] half_gap;
    assign half_gap = r_d[Q-1] - r_rem[Q-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_recip <= WORD_BITS'(r_q[Q-1])
                       + WORD_BITS'(r_rem[Q-1] >= half_gap);
        end
    end

    assign o_recip = r_recip;
endmodule

// ----- tb/tb_cpp_if_note.sv -----
// channel interfaces come from the rtl source files; this file holds the item types
package tb_cpp_types_pkg;

    typedef struct packed {
        logic signed [31:0] rot_x, rot_y, rot_z;
        logic signed [31:0] acc_x, acc_y, acc_z;
        logic signed [31:0] prv_x, prv_y, prv_z;
        logic signed [31:0] cur_x, cur_y, cur_z;
    } t_particle;

    typedef struct packed {
        logic signed [31:0] nx, ny, nz, lx, ly, lz;
    } t_position;

endpackage

// ----- tb/tb_charged_particle_position_push.sv -----
module tb_charged_particle_position_push;
    import cpp_pkg::*;
    import tb_cpp_types_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam longint FIX_ONE = 64'sd16777216;
    localparam int LATENCY = 2 * CPP_FRAC_BITS + 6;
    localparam longint CYCLE_LIMIT = 400000;

    class push_scoreboard;
        longint gain_rot, gain_fld;
        longint box_lo[3], box_hi[3];
        t_position pending[$];
        int n_fail, n_checked;

        function new();
            gain_rot = FIX_ONE; gain_fld = FIX_ONE;
            for (int k = 0; k < 3; k++) begin
                box_lo[k] = WMIN; box_hi[k] = WMAX;
            end
            n_fail = 0; n_checked = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] v);
            longint s;
            s = longint'(signed'(v));
            case (idx)
                CFG_ROT_GAIN: gain_rot = s;
                CFG_FIELD_GAIN: gain_fld = s;
                CFG_X_MIN: box_lo[0] = s;
                CFG_X_MAX: box_hi[0] = s;
                CFG_Y_MIN: box_lo[1] = s;
                CFG_Y_MAX: box_hi[1] = s;
                CFG_Z_MIN: box_lo[2] = s;
                default: box_hi[2] = s;
            endcase
        endfunction

        function longint sat(longint v);
            return v > WMAX ? WMAX : (v < WMIN ? WMIN : v);
        endfunction

        // exact product, round half away from zero, saturate
        function longint fmul(longint a, longint b);
            logic [127:0] m;
            logic [127:0] r;
            bit neg;
            longint mag_r;
            neg = (a < 0) != (b < 0);
            m = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
            r = (m + 128'(64'd1 << (CPP_FRAC_BITS - 1))) >> CPP_FRAC_BITS;
            if (r > 128'(64'd2147483648)) r = 128'(64'd2147483648);
            mag_r = longint'(r[63:0]);
            return neg ? sat(-mag_r) : sat(mag_r);
        endfunction

        function longint fadd(longint a, longint b);
            return sat(a + b);
        endfunction

        function longint fsub(longint a, longint b);
            return sat(a - b);
        endfunction

        // round(2^48 / den), ties upward
        function longint recip_of(longint den);
            logic [127:0] num, q, rm;
            num = 128'(1) << (2 * CPP_FRAC_BITS);
            q = num / 128'(den);
            rm = num % 128'(den);
            if (rm >= 128'(den) - rm) q = q + 1;
            return longint'(q[63:0]);
        endfunction

        function void note_particle(t_particle t);
            longint px, py, pz, ex, ey, ez, ax, ay, az;
            longint pxx, pxy, pxz, pyy, pyz, pzz, r, dx, dy, dz, s;
            longint c[3], n[3], e[3], m[3][3];
            t_position res;
            px = fmul(gain_rot, longint'(t.rot_x)); py = fmul(gain_rot, longint'(t.rot_y));
            pz = fmul(gain_rot, longint'(t.rot_z));
            ex = fmul(gain_fld, longint'(t.acc_x)); ey = fmul(gain_fld, longint'(t.acc_y));
            ez = fmul(gain_fld, longint'(t.acc_z));
            ax = longint'(t.prv_x); ay = longint'(t.prv_y); az = longint'(t.prv_z);
            c[0] = longint'(t.cur_x); c[1] = longint'(t.cur_y); c[2] = longint'(t.cur_z);
            pxx = fmul(px, px); pxy = fmul(px, py); pxz = fmul(px, pz);
            pyy = fmul(py, py); pyz = fmul(py, pz); pzz = fmul(pz, pz);
            r = recip_of(fadd(fadd(fadd(FIX_ONE, pxx), pyy), pzz));
            dx = fadd(fsub(fsub(fadd(c[0], c[0]), ax), fmul(pz, ay)), fmul(py, az));
            dy = fadd(fsub(fsub(fadd(c[1], c[1]), ay), fmul(px, az)), fmul(pz, ax));
            dz = fadd(fsub(fsub(fadd(c[2], c[2]), az), fmul(py, ax)), fmul(px, ay));
            m[0][0] = fadd(FIX_ONE, pxx); m[0][1] = fadd(pz, pxy); m[0][2] = fsub(pxz, py);
            m[1][0] = fsub(pxy, pz); m[1][1] = fadd(FIX_ONE, pyy); m[1][2] = fadd(pyz, px);
            m[2][0] = fadd(pxz, py); m[2][1] = fsub(pyz, px); m[2][2] = fadd(FIX_ONE, pzz);
            e[0] = ex; e[1] = ey; e[2] = ez;
            for (int k = 0; k < 3; k++) begin
                s = fadd(fadd(fmul(m[k][0], dx), fmul(m[k][1], dy)), fmul(m[k][2], dz));
                n[k] = fadd(fmul(r, s), e[k]);
                // min test first, so an inverted box ends on the max bound
                if (n[k] < box_lo[k]) begin
                    n[k] = box_lo[k]; c[k] = box_lo[k];
                end
                if (n[k] > box_hi[k]) begin
                    n[k] = box_hi[k]; c[k] = box_hi[k];
                end
            end
            res.nx = 32'(n[0]); res.ny = 32'(n[1]); res.nz = 32'(n[2]);
            res.lx = 32'(c[0]); res.ly = 32'(c[1]); res.lz = 32'(c[2]);
            pending = {pending, res};
        endfunction

        function void check_position(t_position got);
            t_position exp_pos;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                n_fail++;
                return;
            end
            exp_pos = pending.pop_front();
            n_checked++;
            if (got.nx !== exp_pos.nx)
                $display("%0t: next_x exp %h got %h", $time, exp_pos.nx, got.nx);
            if (got.ny !== exp_pos.ny)
                $display("%0t: next_y exp %h got %h", $time, exp_pos.ny, got.ny);
            if (got.nz !== exp_pos.nz)
                $display("%0t: next_z exp %h got %h", $time, exp_pos.nz, got.nz);
            if (got.lx !== exp_pos.lx)
                $display("%0t: last_x exp %h got %h", $time, exp_pos.lx, got.lx);
            if (got.ly !== exp_pos.ly)
                $display("%0t: last_y exp %h got %h", $time, exp_pos.ly, got.ly);
            if (got.lz !== exp_pos.lz)
                $display("%0t: last_z exp %h got %h", $time, exp_pos.lz, got.lz);
            if (got !== exp_pos) n_fail++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CPP_CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    longint cycle_cnt = 0;
    bit src_idle_on = 1'b1;
    bit snk_idle_on = 1'b1;
    bit snk_hold = 1'b0;
    push_scoreboard sb;

    cpp_in_if #(.WORD_BITS(32)) item_ch ();
    cpp_out_if #(.WORD_BITS(32)) res_ch ();

    charged_particle_position_push i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_item(item_ch.sink), .o_res(res_ch.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        item_ch.valid = 1'b0;
        {item_ch.rot_x, item_ch.rot_y, item_ch.rot_z} = '0;
        {item_ch.accel_x, item_ch.accel_y, item_ch.accel_z} = '0;
        {item_ch.prev_x, item_ch.prev_y, item_ch.prev_z} = '0;
        {item_ch.cur_x, item_ch.cur_y, item_ch.cur_z} = '0;
        res_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_charged_particle_position_push NOT OK");
            $finish;
        end
    end

    // receiver: random stalls, optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n || snk_hold) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= !snk_idle_on || ($urandom_range(99) >= 25);
        end
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_position({res_ch.next_x, res_ch.next_y, res_ch.next_z,
                               res_ch.last_x, res_ch.last_y, res_ch.last_z});
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        sb.set_reg(idx, v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // valid stays high after a transfer until the next item or an idle cycle
    task automatic send_particle(t_particle t);
        while (src_idle_on && $urandom_range(99) < 25) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        {item_ch.rot_x, item_ch.rot_y, item_ch.rot_z} <= {t.rot_x, t.rot_y, t.rot_z};
        {item_ch.accel_x, item_ch.accel_y, item_ch.accel_z} <=
            {t.acc_x, t.acc_y, t.acc_z};
        {item_ch.prev_x, item_ch.prev_y, item_ch.prev_z} <= {t.prv_x, t.prv_y, t.prv_z};
        {item_ch.cur_x, item_ch.cur_y, item_ch.cur_z} <= {t.cur_x, t.cur_y, t.cur_z};
        do @(posedge i_clk); while (!item_ch.ready);
        sb.note_particle(t);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // mix of small physical values and full-range words
    function automatic logic [31:0] pick_word(int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(8, 0) * 32'sd1) - 4) <<< 22
                      ^ ($urandom() & 32'h3fffff);
            2: return ($urandom_range(1) ? 32'h7fffffff : 32'h80000000);
            default: return 32'($signed($urandom() & 32'h00ffffff) - 32'sh00800000);
        endcase
    endfunction

    function automatic t_particle rand_particle();
        t_particle t;
        int kind;
        kind = $urandom_range(99) < 15 ? 0 : ($urandom_range(99) < 5 ? 2 : 3);
        t.rot_x = pick_word(kind); t.rot_y = pick_word(kind); t.rot_z = pick_word(kind);
        t.acc_x = pick_word(kind); t.acc_y = pick_word(kind); t.acc_z = pick_word(kind);
        kind = $urandom_range(99) < 20 ? 0 : 1;
        t.prv_x = pick_word(kind); t.prv_y = pick_word(kind); t.prv_z = pick_word(kind);
        t.cur_x = pick_word(kind); t.cur_y = pick_word(kind); t.cur_z = pick_word(kind);
        return t;
    endfunction

    task automatic directed_set();
        t_particle t;
        logic [31:0] edges[5];
        edges = '{32'h00000000, 32'h7fffffff, 32'h80000000, 32'h01000000, 32'hff000000};
        for (int i = 0; i < 5; i++) begin
            t = {12{edges[i]}};
            send_particle(t);
        end
        t = '0;
        t.cur_x = 32'h01000000; t.prv_x = 32'h00800000;
        send_particle(t);
        t.rot_z = 32'h00400000;
        send_particle(t);
        t.acc_y = 32'hfff00000; t.rot_x = 32'h7fffffff;
        send_particle(t);
        t = {12{32'h55555555}};
        send_particle(t);
        t = {12{32'haaaaaaaa}};
        send_particle(t);
        for (int i = 0; i < 6; i++) send_particle(rand_particle());
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) send_particle(rand_particle());
    endtask

    task automatic rand_box();
        for (int k = 0; k < 3; k++) begin
            logic signed [31:0] a, b;
            a = pick_word(1); b = pick_word(1);
            if ($urandom_range(3) != 0 && a > b) {a, b} = {b, a};
            write_reg(t_cfg_idx'(CFG_X_MIN + 2 * k), a);
            write_reg(t_cfg_idx'(CFG_X_MAX + 2 * k), b);
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_set();
        drain();

        // extreme gains and an inverted box
        write_reg(CFG_ROT_GAIN, 32'h7fffffff);
        write_reg(CFG_FIELD_GAIN, 32'h80000000);
        write_reg(CFG_X_MIN, 32'h01000000);
        write_reg(CFG_X_MAX, 32'hff000000);
        write_reg(CFG_Y_MIN, 32'h80000000);
        write_reg(CFG_Y_MAX, 32'h7fffffff);
        write_reg(CFG_Z_MIN, 32'hfe000000);
        write_reg(CFG_Z_MAX, 32'h02000000);
        random_phase(60);
        drain();

        write_reg(CFG_ROT_GAIN, 32'h00000000);
        write_reg(CFG_FIELD_GAIN, 32'h00000000);
        rand_box();
        random_phase(60);
        drain();

        // long hold-off so the pipe fills and stalls the input
        write_reg(CFG_ROT_GAIN, 32'h00400000);
        write_reg(CFG_FIELD_GAIN, 32'h01000000);
        src_idle_on = 1'b0;
        fork
            begin
                snk_hold = 1'b1;
                repeat (300) @(posedge i_clk);
                snk_hold = 1'b0;
            end
            random_phase(200);
        join
        drain();

        // long stretch with no idling on either side
        snk_idle_on = 1'b0;
        rand_box();
        random_phase(300);
        drain();
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_ROT_GAIN, pick_word($urandom_range(1) ? 3 : 0));
            write_reg(CFG_FIELD_GAIN, pick_word(3));
            rand_box();
            random_phase(200);
            drain();
        end

        $display("covered %0d particles over gain extremes, inverted and random boxes,",
                 sb.n_checked);
        $display("saturating inputs, random stalls and a long output hold-off");
        if (sb.n_fail == 0 && sb.pending.size() == 0) begin
            $display("tb_charged_particle_position_push OK");
        end else begin
            $display("tb_charged_particle_position_push NOT OK");
        end
        $finish;
    end
endmodule

// ----- charged_particle_position_push.f -----
src/cpp_pkg.sv
src/cpp_in_if.sv
src/cpp_out_if.sv
src/cpp_recip.sv
src/charged_particle_position_push.sv
tb/tb_cpp_if_note.sv
tb/tb_charged_particle_position_push.sv
